// File: sv/csosc_pkg.sv
// ----------------------------------------------------------------------------
// csosc_pkg
// Shared constants, register indexes and the quarter-wave sine table builder
// for the controlled sine oscillator.
// ----------------------------------------------------------------------------
package csosc_pkg;

  // sine table geometry
  localparam int SINE_TABLE_BITS = 10;
  localparam int TBL_N           = 1 << SINE_TABLE_BITS;
  localparam int TBL_AW          = SINE_TABLE_BITS + 1;

  // item and register widths
  localparam int CTRL_W   = 16;
  localparam int SAMPLE_W = 18;
  localparam int AMP_W    = 16;
  localparam int PSTEP_W  = 20;
  localparam int PHASE_W  = 32;
  localparam int SINE_W   = 17;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 20;

  // shared multiplier geometry
  localparam int MUL_AW = 26;
  localparam int MUL_BW = 21;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int FREQ_W = 25;

  // frequency law: 200 Hz base in Q16, 300 Hz per 65536 units of gain
  localparam logic [FREQ_W-1:0] FREQ_BASE  = 25'd13107200;
  localparam logic [MUL_AW-1:0] GAIN_SLOPE = 26'd300;

  // register reset values
  localparam logic                MODE_RESET  = 1'b1;
  localparam logic [AMP_W-1:0]    AMP_RESET   = '0;
  localparam logic [PSTEP_W-1:0]  PSTEP_RESET = 20'd89478;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IW-1:0] REG_PSTEP     = 2'd2;

  // table math constants (Q30)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef logic [15:0] sine_rom_t [0:TBL_N];

  // one table entry: Horner series through x^11 in Q30, rounded to Q15
  function automatic logic [15:0] quarter_sine(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    r  = ONE_Q30;
    for (int j = 0; j < 5; j++) begin
      t = (x2 * r) >> 30;
      case (j)
        0:       t = t / 64'd110;
        1:       t = t / 64'd72;
        2:       t = t / 64'd42;
        3:       t = t / 64'd20;
        default: t = t / 64'd6;
      endcase
      r = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    end
    s = (x * r) >> 30;
    return 16'((s + (64'd1 << 14)) >> 15);
  endfunction

  // whole quarter-wave table, worked out at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= TBL_N; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

endpackage

// File: sv/controlled_sine_oscillator.sv
// ----------------------------------------------------------------------------
// controlled_sine_oscillator
// The sequencer takes an item in IDLE, then steps through LOOK, SINE and STEP,
// running three products through one shared 26x21 multiplier after a
// registered sine table read, and loads the output register in DONE, where it
// waits while the output stalls. Reset (synchronous) clears the phase to zero,
// loads the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module controlled_sine_oscillator (
  input  logic                                  clk,
  input  logic                                  rst,
  // control items
  input  logic                                  control_valid,
  output logic                                  control_stall,
  input  logic signed [csosc_pkg::CTRL_W-1:0]   control_level,
  // sample items
  output logic                                  sample_valid,
  input  logic                                  sample_stall,
  output logic signed [csosc_pkg::SAMPLE_W-1:0] sample_out,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [csosc_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [csosc_pkg::CFG_DW-1:0]          cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_SINE = 5'b00100,
    S_STEP = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic                                 mode;
  logic [csosc_pkg::AMP_W-1:0]          amplitude;
  logic [csosc_pkg::PSTEP_W-1:0]        phase_step_per_hz;
  logic [csosc_pkg::PHASE_W-1:0]        phase;
  logic [csosc_pkg::CTRL_W-1:0]         gain;
  logic [csosc_pkg::FREQ_W-1:0]         freq;
  logic signed [csosc_pkg::PROD_W-1:0]  prod;
  logic signed [csosc_pkg::SAMPLE_W-1:0] y_r;

  logic signed [csosc_pkg::SINE_W-1:0]  sine;
  logic signed [csosc_pkg::MUL_AW-1:0]  mul_a;
  logic signed [csosc_pkg::MUL_BW-1:0]  mul_b;
  logic signed [csosc_pkg::PROD_W-1:0]  rnd_ctl;
  logic signed [csosc_pkg::PROD_W-1:0]  rnd_fix;
  logic signed [csosc_pkg::PROD_W-1:0]  y_wide;
  logic [csosc_pkg::PHASE_W-1:0]        step;
  logic                                 accept;
  logic                                 out_load;

  assign control_stall = (state != S_IDLE);
  assign accept        = control_valid && !control_stall;
  assign cfg_ready     = 1'b1;
  assign out_load      = (state == S_DONE) && (!sample_valid || !sample_stall);

  // sine lookup from the current phase
  csosc_sine_rom u_rom (
    .clk   (clk),
    .phase (phase),
    .sine  (sine)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= csosc_pkg::MODE_RESET;
      amplitude         <= csosc_pkg::AMP_RESET;
      phase_step_per_hz <= csosc_pkg::PSTEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csosc_pkg::REG_MODE:      mode              <= cfg_data[0];
        csosc_pkg::REG_AMPLITUDE: amplitude         <= cfg_data[csosc_pkg::AMP_W-1:0];
        csosc_pkg::REG_PSTEP:     phase_step_per_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_LOOK;
      S_LOOK:  state_next = S_SINE;
      S_SINE:  state_next = S_STEP;
      S_STEP:  state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LOOK: begin
        mul_a = csosc_pkg::GAIN_SLOPE;
        mul_b = {5'b0, gain};
      end
      S_SINE: begin
        mul_a = {{(csosc_pkg::MUL_AW-csosc_pkg::SINE_W){sine[csosc_pkg::SINE_W-1]}}, sine};
        mul_b = {5'b0, (mode ? gain : amplitude)};
      end
      S_STEP: begin
        mul_a = {1'b0, freq};
        mul_b = {1'b0, phase_step_per_hz};
      end
      default: ;
    endcase
  end

  // round half up, then clamp to the range -98304 to 32767
  always_comb begin
    rnd_ctl = (prod + 47'sd32768) >>> 16;
    rnd_fix = ((prod + 47'sd16384) >>> 15) - 47'sd32768;
    y_wide  = mode ? rnd_ctl : rnd_fix;
    if (y_wide > 47'sd32767) begin
      y_wide = 47'sd32767;
    end else if (y_wide < -47'sd98304) begin
      y_wide = -47'sd98304;
    end
  end

  // phase increment from the frequency product
  assign step = mode ? {1'b0, prod[csosc_pkg::PROD_W-1:16]} : prod[43:12];

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          gain <= {~control_level[csosc_pkg::CTRL_W-1], control_level[csosc_pkg::CTRL_W-2:0]};
        end
      end
      S_LOOK: begin
        prod <= mul_a * mul_b;
      end
      S_SINE: begin
        freq <= mode ? csosc_pkg::FREQ_BASE + prod[csosc_pkg::FREQ_W-1:0]
                     : {{(csosc_pkg::FREQ_W-csosc_pkg::AMP_W){1'b0}}, amplitude};
        prod <= mul_a * mul_b;
      end
      S_STEP: begin
        y_r  <= y_wide[csosc_pkg::SAMPLE_W-1:0];
        prod <= mul_a * mul_b;
      end
      default: ;
    endcase
  end

  // phase accumulator advances once the sample is handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (out_load) begin
      phase <= phase + step;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (out_load) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= y_r;
    end
  end

endmodule

// File: sv/csosc_sine_rom.sv
// ----------------------------------------------------------------------------
// csosc_sine_rom
// Quarter-wave sine lookup: folds the phase into the table, reads the entry
// with a registered read and restores the sign of the lower half cycle.
// ----------------------------------------------------------------------------
module csosc_sine_rom (
  input  logic                                   clk,
  input  logic [csosc_pkg::PHASE_W-1:0]          phase,
  output logic signed [csosc_pkg::SINE_W-1:0]    sine
);

  localparam csosc_pkg::sine_rom_t ROM = csosc_pkg::build_sine_rom();

  logic [csosc_pkg::SINE_TABLE_BITS-1:0] idx;
  logic [csosc_pkg::TBL_AW-1:0]          addr;
  logic [15:0]                           rom_q;
  logic                                  neg_q;

  // mirror the index in the second and fourth quadrants
  always_comb begin
    idx  = phase[csosc_pkg::PHASE_W-3 -: csosc_pkg::SINE_TABLE_BITS];
    addr = phase[csosc_pkg::PHASE_W-2]
         ? csosc_pkg::TBL_AW'(csosc_pkg::TBL_N) - {1'b0, idx}
         : {1'b0, idx};
  end

  // registered table read
  always_ff @(posedge clk) begin
    rom_q <= ROM[addr];
    neg_q <= phase[csosc_pkg::PHASE_W-1];
  end

  // negative half cycle
  assign sine = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the controlled sine oscillator. A directed table
// covers reset values, phase landing on the sine peak, output saturation,
// both modes, an unused register index and out-of-width register bits. A
// long random part follows, in phases with different register settings.
// Every sample is checked against a known value or a local model of the phase
// accumulator, the quarter-wave table and the gain and amplitude arithmetic.
// ----------------------------------------------------------------------------
module testbench;
  import csosc_pkg::*;

  typedef longint unsigned u64_t;

  localparam u64_t Q30_HALF_PI = 64'd1686629713;
  localparam u64_t Q30_ONE     = 64'd1 << 30;
  localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -98304;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PLAN_LEN      = 31;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 136;
  localparam int REPORT_MAX    = 10;

  // one row of the directed table: a register write or a control item
  typedef struct packed {
    logic                       is_cfg;
    logic [CFG_IW-1:0]          idx;
    logic [CFG_DW-1:0]          data;
    logic signed [CTRL_W-1:0]   level;
    logic                       known;
    logic signed [SAMPLE_W-1:0] value;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic control_valid = 1'b0;
  logic control_stall;
  logic signed [CTRL_W-1:0] control_level = '0;
  logic sample_valid;
  logic sample_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  // oscillator model state and registers
  logic [PHASE_W-1:0] osc_phase;
  logic               osc_mode;
  logic [AMP_W-1:0]   osc_amp;
  logic [PSTEP_W-1:0] osc_pstep;
  int                 sine_q15 [0:TBL_N];

  logic signed [SAMPLE_W-1:0] pending_samples [$];
  plan_row_t plan [0:PLAN_LEN-1];

  bit no_idle = 1'b0;
  int items_sent = 0;
  int samples_checked = 0;
  int reg_writes = 0;
  int fail_count = 0;
  int reports = 0;
  int cycle_count = 0;

  controlled_sine_oscillator u_dut (
    .clk           (clk),
    .rst           (rst),
    .control_valid (control_valid),
    .control_stall (control_stall),
    .control_level (control_level),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample_out    (sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // quarter-wave entry: Taylor series in Q30 by Horner's rule, rounded to Q15
  function automatic int quarter_wave_entry(int k);
    u64_t x;
    u64_t x2;
    u64_t r;
    u64_t t;
    u64_t horner_div [0:4];
    horner_div = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    x  = (u64_t'(k) * Q30_HALF_PI) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    r  = Q30_ONE;
    for (int j = 0; j < 5; j++) begin
      t = ((x2 * r) >> 30) / horner_div[j];
      r = (t > Q30_ONE) ? 64'd0 : Q30_ONE - t;
    end
    t = (x * r) >> 30;
    return int'((t + 64'd16384) >> 15);
  endfunction

  // sample for the current phase, then advance the phase
  function automatic logic signed [SAMPLE_W-1:0] oscillate(logic signed [CTRL_W-1:0] level);
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    longint                     sine;
    longint                     gain;
    longint                     amp;
    longint                     pstep;
    longint                     y;
    longint                     adv;
    quad  = osc_phase[PHASE_W-1 -: 2];
    idx   = osc_phase[PHASE_W-3 -: SINE_TABLE_BITS];
    sine  = quad[0] ? sine_q15[TBL_N - idx] : sine_q15[idx];
    if (quad[1]) sine = -sine;
    amp   = osc_amp;
    pstep = osc_pstep;
    if (osc_mode) begin
      gain = longint'(level) + 32768;
      y    = (gain * sine + 32768) >>> 16;
      adv  = ((longint'(200) * 65536 + 300 * gain) * pstep) >>> 16;
    end else begin
      y   = ((amp * sine + 16384) >>> 15) - 32768;
      adv = (amp * pstep) >>> 12;
    end
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    osc_phase = osc_phase + adv[PHASE_W-1:0];
    return y[SAMPLE_W-1:0];
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic plan_row_t level_row(logic signed [CTRL_W-1:0] level);
    plan_row_t row;
    row = '0;
    row.level = level;
    return row;
  endfunction

  function automatic plan_row_t known_row(logic signed [CTRL_W-1:0] level,
                                          logic signed [SAMPLE_W-1:0] value);
    plan_row_t row;
    row = '0;
    row.level = level;
    row.known = 1'b1;
    row.value = value;
    return row;
  endfunction

  function automatic void note_failure(string what, logic signed [SAMPLE_W-1:0] expd,
                                       logic signed [SAMPLE_W-1:0] got);
    fail_count++;
    if (reports < REPORT_MAX) begin
      reports++;
      $display("%s at sample %0d: expected %0d, got %0d", what, samples_checked, expd, got);
    end
  endfunction

  // send one control item and queue its expected sample (known or predicted)
  task automatic send_level(logic signed [CTRL_W-1:0] level, logic known,
                            logic signed [SAMPLE_W-1:0] value);
    int gap;
    logic signed [SAMPLE_W-1:0] predicted;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      control_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    control_valid <= 1'b1;
    control_level <= level;
    do @(posedge clk); while (control_stall);
    predicted = oscillate(level);
    pending_samples.push_back(known ? value : predicted);
    items_sent++;
  endtask

  // hold off until every sample has come and the pipeline is quiet
  task automatic drain_results();
    control_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; valid is kept high when another write follows
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:      osc_mode  = data[0];
      REG_AMPLITUDE: osc_amp   = data[AMP_W-1:0];
      REG_PSTEP:     osc_pstep = data[PSTEP_W-1:0];
      default:       ;
    endcase
    reg_writes++;
  endtask

  // sample side: random stalls, check each accepted item in order
  initial begin
    int hold;
    logic signed [SAMPLE_W-1:0] expd;
    while (rst) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        sample_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        sample_stall <= 1'b0;
      end
      do @(posedge clk); while (!sample_valid);
      if (pending_samples.size() == 0) begin
        note_failure("unexpected sample", '0, sample_out);
      end else begin
        expd = pending_samples.pop_front();
        if (sample_out !== expd) note_failure("mismatch", expd, sample_out);
        samples_checked++;
      end
    end
  end

  // stimulus
  initial begin
    logic mode_bit;
    logic [AMP_W-1:0] amp_pick;
    logic [PSTEP_W-1:0] pstep_pick;
    logic signed [CTRL_W-1:0] level_pick;
    bit last_row;

    for (int k = 0; k <= TBL_N; k++) sine_q15[k] = quarter_wave_entry(k);
    osc_phase = '0;
    osc_mode  = MODE_RESET;
    osc_amp   = AMP_RESET;
    osc_pstep = PSTEP_RESET;

    // six control items at the least level walk the phase onto the sine
    // peak; with a zero step the peak then holds for the checks that follow
    plan = '{
      known_row(-32768, 0),
      reg_row(REG_PSTEP, 20'd880000),
      known_row(-32768, 0), known_row(-32768, 0), known_row(-32768, 0),
      known_row(-32768, 0), known_row(-32768, 0), known_row(-32768, 0),
      reg_row(REG_PSTEP, 20'd0),
      known_row(32767, 32767),
      level_row(0),
      level_row(-1),
      reg_row(REG_MODE, 20'd0),
      reg_row(REG_AMPLITUDE, 20'd65535),
      known_row(16'sh1234, 32767),
      reg_row(REG_AMPLITUDE, 20'd0),
      known_row(-1, -32768),
      reg_row(REG_SPARE, 20'hFFFFF),
      known_row(32767, -32768),
      reg_row(REG_AMPLITUDE, 20'hF8000),
      reg_row(REG_PSTEP, 20'hFFFFF),
      level_row(0), level_row(16'sh5555), level_row(-32768),
      reg_row(REG_MODE, 20'hFFFFE),
      level_row(-21846),
      reg_row(REG_MODE, 20'h00001),
      known_row(-32768, 0),
      level_row(32767), level_row(0), level_row(16'sh5555)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].is_cfg) begin
        if (r == 0 || !plan[r-1].is_cfg) drain_results();
        last_row = (r == PLAN_LEN - 1) || !plan[r+1].is_cfg;
        write_reg(plan[r].idx, plan[r].data, last_row);
      end else begin
        send_level(plan[r].level, plan[r].known, plan[r].value);
      end
    end

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      no_idle  = (p % 4 == 2);
      mode_bit = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0:       amp_pick = '0;
        1:       amp_pick = '1;
        default: amp_pick = AMP_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       pstep_pick = '0;
        1:       pstep_pick = '1;
        2:       pstep_pick = PSTEP_RESET;
        default: pstep_pick = PSTEP_W'($urandom);
      endcase
      write_reg(REG_MODE, {19'($urandom), mode_bit}, 1'b0);
      write_reg(REG_AMPLITUDE, {4'($urandom), amp_pick}, 1'b0);
      if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, CFG_DW'($urandom), 1'b0);
      write_reg(REG_PSTEP, pstep_pick, 1'b1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits for every sample mid-phase once
        if (p == 5 && n == PHASE_ITEMS / 2) drain_results();
        case ($urandom_range(0, 7))
          0:       level_pick = 16'sh7FFF;
          1:       level_pick = 16'sh8000;
          2:       level_pick = '0;
          default: level_pick = CTRL_W'($urandom);
        endcase
        send_level(level_pick, 1'b0, '0);
      end
    end

    // wind down
    control_valid <= 1'b0;
    no_idle = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_samples.size() != 0) fail_count += pending_samples.size();

    $display("%0d control items over a directed table and %0d random register phases",
             items_sent, PHASES);
    $display("%0d samples checked, %0d register writes, %0d failures",
             samples_checked, reg_writes, fail_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/csosc_pkg.sv
sv/csosc_sine_rom.sv
sv/controlled_sine_oscillator.sv
tb/testbench.sv
